[rtl/cia_pkg.sv]
// ----------------------------------------------------------------------------
// cia_pkg
// shared types and constants of the complex integer alu
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned MaxOperandWidth = 32;
  localparam int unsigned FieldWidth      = 16;
  localparam int unsigned OpWidth         = 3;
  localparam int unsigned ResWidth        = 33;
  localparam int unsigned OrderWidth      = 2;
  localparam int unsigned InDataWidth     = 72;
  localparam int unsigned OutDataWidth    = 72;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_INC = 3'd4,
    OP_DEC = 3'd5,
    OP_CMP = 3'd6,
    OP_NOP = 3'd7
  } op_e;

  typedef enum logic [OrderWidth-1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2,
    ORD_NONE    = 2'd3
  } order_e;

endpackage

[rtl/cia_div_pipe.sv]
// ----------------------------------------------------------------------------
// cia_div_pipe
// two-lane restoring divider, one quotient bit per stage, side data in step
// ----------------------------------------------------------------------------
module cia_div_pipe #(
  parameter int unsigned OperandWidth = cia_pkg::OperandWidthDef,
  parameter int unsigned SideWidth    = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [2*OperandWidth:0]  num_re_i,
  input  logic [2*OperandWidth:0]  num_im_i,
  input  logic [2*OperandWidth-1:0] div_i,
  input  logic [SideWidth-1:0]     side_i,
  output logic                     valid_o,
  output logic [2*OperandWidth:0]  quo_re_o,
  output logic [2*OperandWidth:0]  quo_im_o,
  output logic [SideWidth-1:0]     side_o
);

  localparam int unsigned NW = 2 * OperandWidth + 1;
  localparam int unsigned DW = 2 * OperandWidth;

  logic          vld_q   [1:NW];
  logic [NW-1:0] nre_q   [1:NW];
  logic [NW-1:0] nim_q   [1:NW];
  logic [DW-1:0] rre_q   [1:NW];
  logic [DW-1:0] rim_q   [1:NW];
  logic [NW-1:0] qre_q   [1:NW];
  logic [NW-1:0] qim_q   [1:NW];
  logic [DW-1:0] dv_q    [1:NW];
  logic [SideWidth-1:0] sd_q [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic                 v_in;
    logic [NW-1:0]        nre_in;
    logic [NW-1:0]        nim_in;
    logic [DW-1:0]        rre_in;
    logic [DW-1:0]        rim_in;
    logic [NW-1:0]        qre_in;
    logic [NW-1:0]        qim_in;
    logic [DW-1:0]        dv_in;
    logic [SideWidth-1:0] sd_in;
    logic [DW:0]   tre;
    logic [DW:0]   tim;
    logic          gre;
    logic          gim;
    logic [DW:0]   sre;
    logic [DW:0]   sim;

    if (k == 0) begin : g_head
      assign v_in   = valid_i;
      assign nre_in = num_re_i;
      assign nim_in = num_im_i;
      assign rre_in = '0;
      assign rim_in = '0;
      assign qre_in = '0;
      assign qim_in = '0;
      assign dv_in  = div_i;
      assign sd_in  = side_i;
    end else begin : g_tail
      assign v_in   = vld_q[k];
      assign nre_in = nre_q[k];
      assign nim_in = nim_q[k];
      assign rre_in = rre_q[k];
      assign rim_in = rim_q[k];
      assign qre_in = qre_q[k];
      assign qim_in = qim_q[k];
      assign dv_in  = dv_q[k];
      assign sd_in  = sd_q[k];
    end

    always_comb begin
      tre = {rre_in, nre_in[NW-1]};
      tim = {rim_in, nim_in[NW-1]};
      gre = (tre >= {1'b0, dv_in});
      gim = (tim >= {1'b0, dv_in});
      sre = gre ? (tre - {1'b0, dv_in}) : tre;
      sim = gim ? (tim - {1'b0, dv_in}) : tim;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nre_q[k+1] <= {nre_in[NW-2:0], 1'b0};
        nim_q[k+1] <= {nim_in[NW-2:0], 1'b0};
        rre_q[k+1] <= sre[DW-1:0];
        rim_q[k+1] <= sim[DW-1:0];
        qre_q[k+1] <= {qre_in[NW-2:0], gre};
        qim_q[k+1] <= {qim_in[NW-2:0], gim};
        dv_q[k+1]  <= dv_in;
        sd_q[k+1]  <= sd_in;
      end
    end
  end

  assign valid_o  = vld_q[NW];
  assign quo_re_o = qre_q[NW];
  assign quo_im_o = qim_q[NW];
  assign side_o   = sd_q[NW];

endmodule

[rtl/complex_integer_alu_unit.sv]
// ----------------------------------------------------------------------------
// complex_integer_alu_unit
// pipelined alu for gaussian integers: add, sub, mul, div, inc, dec, compare
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit first)
// s_axis   in   op[2:0] a_re[18:3] a_im[34:19] b_re[50:35] b_im[66:51]
// m_axis   out  res_re[32:0] res_im[65:33] order[67:66] div_zero[68]
//
// one item per cycle while the output register is not held; the divider
// resolves one quotient bit per stage.
// every op goes through the same stages, so results leave in order.
// the whole pipeline holds while a result waits at the output register.
// reset clears the valid bits only.
// ----------------------------------------------------------------------------
module complex_integer_alu_unit #(
  parameter int unsigned OPERAND_WIDTH = cia_pkg::OperandWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // op, a_re, a_im, b_re, b_im
  input  logic [cia_pkg::InDataWidth-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // res_re, res_im, order, div_zero
  output logic [cia_pkg::OutDataWidth-1:0] m_axis_tdata_o
);

  localparam int unsigned W   = OPERAND_WIDTH;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned SW  = 2 * W + 1;
  localparam int unsigned FW  = 2 * W + 2;
  localparam int unsigned RW  = cia_pkg::ResWidth;
  localparam int unsigned OW  = cia_pkg::OpWidth;
  localparam int unsigned OrW = cia_pkg::OrderWidth;
  localparam int unsigned SDW = OW + 3 + OrW + 2 * SW;
  localparam int unsigned FB  = cia_pkg::FieldWidth;

  logic en;
  logic out_valid_q;
  logic [cia_pkg::OutDataWidth-1:0] out_data_q;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // stage 0: operand capture and zero extension
  logic [cia_pkg::MaxOperandWidth-1:0] zar, zai, zbr, zbi;
  logic                  v0_q;
  cia_pkg::op_e          op0_q;
  logic signed [W-1:0]   ar0_q, ai0_q, br0_q, bi0_q;

  always_comb begin
    zar = {{(cia_pkg::MaxOperandWidth-FB){1'b0}}, s_axis_tdata_i[OW+:FB]};
    zai = {{(cia_pkg::MaxOperandWidth-FB){1'b0}}, s_axis_tdata_i[OW+FB+:FB]};
    zbr = {{(cia_pkg::MaxOperandWidth-FB){1'b0}}, s_axis_tdata_i[OW+2*FB+:FB]};
    zbi = {{(cia_pkg::MaxOperandWidth-FB){1'b0}}, s_axis_tdata_i[OW+3*FB+:FB]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q <= cia_pkg::op_e'(s_axis_tdata_i[OW-1:0]);
      ar0_q <= $signed(zar[W-1:0]);
      ai0_q <= $signed(zai[W-1:0]);
      br0_q <= $signed(zbr[W-1:0]);
      bi0_q <= $signed(zbi[W-1:0]);
    end
  end

  // stage 1: products and linear results
  logic                  v1_q;
  cia_pkg::op_e          op1_q;
  logic signed [PW-1:0]  p_arbr_q, p_aibi_q, p_arbi_q, p_aibr_q;
  logic signed [PW-1:0]  p_arar_q, p_aiai_q, p_brbr_q, p_bibi_q;
  logic signed [SW-1:0]  lin_re_d, lin_im_d, lin_re_q, lin_im_q;

  always_comb begin
    case (op0_q)
      cia_pkg::OP_ADD: begin
        lin_re_d = SW'(ar0_q) + SW'(br0_q);
        lin_im_d = SW'(ai0_q) + SW'(bi0_q);
      end
      cia_pkg::OP_SUB: begin
        lin_re_d = SW'(ar0_q) - SW'(br0_q);
        lin_im_d = SW'(ai0_q) - SW'(bi0_q);
      end
      cia_pkg::OP_INC: begin
        lin_re_d = SW'(ar0_q) + SW'(1);
        lin_im_d = SW'(ai0_q) + SW'(1);
      end
      cia_pkg::OP_DEC: begin
        lin_re_d = SW'(ar0_q) - SW'(1);
        lin_im_d = SW'(ai0_q) - SW'(1);
      end
      default: begin
        lin_re_d = '0;
        lin_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q    <= op0_q;
      p_arbr_q <= PW'(ar0_q) * PW'(br0_q);
      p_aibi_q <= PW'(ai0_q) * PW'(bi0_q);
      p_arbi_q <= PW'(ar0_q) * PW'(bi0_q);
      p_aibr_q <= PW'(ai0_q) * PW'(br0_q);
      p_arar_q <= PW'(ar0_q) * PW'(ar0_q);
      p_aiai_q <= PW'(ai0_q) * PW'(ai0_q);
      p_brbr_q <= PW'(br0_q) * PW'(br0_q);
      p_bibi_q <= PW'(bi0_q) * PW'(bi0_q);
      lin_re_q <= lin_re_d;
      lin_im_q <= lin_im_d;
    end
  end

  // stage 2: sums, divisor, compare
  logic signed [SW-1:0]  num_re, num_im, rr_d, ri_d;
  logic [PW-1:0]         dv_d, ma, mb;
  logic [SW-1:0]         mag_re_d, mag_im_d;
  logic                  dz_d;
  cia_pkg::order_e       ord_d;
  logic                  v2_q;
  logic [SW-1:0]         mag_re_q, mag_im_q;
  logic [PW-1:0]         dv_q;
  logic [SDW-1:0]        side_q;

  always_comb begin
    num_re   = SW'(p_arbr_q) + SW'(p_aibi_q);
    num_im   = SW'(p_aibr_q) - SW'(p_arbi_q);
    mag_re_d = num_re[SW-1] ? SW'(-num_re) : SW'(num_re);
    mag_im_d = num_im[SW-1] ? SW'(-num_im) : SW'(num_im);
    dv_d     = $unsigned(p_brbr_q) + $unsigned(p_bibi_q);
    ma       = $unsigned(p_arar_q) + $unsigned(p_aiai_q);
    mb       = dv_d;
    dz_d     = (op1_q == cia_pkg::OP_DIV) && (dv_d == '0);
    ord_d    = cia_pkg::ORD_LESS;
    if (op1_q == cia_pkg::OP_CMP) begin
      if (ma < mb) begin
        ord_d = cia_pkg::ORD_LESS;
      end else if (ma == mb) begin
        ord_d = cia_pkg::ORD_EQUAL;
      end else begin
        ord_d = cia_pkg::ORD_GREATER;
      end
    end
    if (op1_q == cia_pkg::OP_MUL) begin
      rr_d = SW'(p_arbr_q) - SW'(p_aibi_q);
      ri_d = SW'(p_arbi_q) + SW'(p_aibr_q);
    end else begin
      rr_d = lin_re_q;
      ri_d = lin_im_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_re_q <= mag_re_d;
      mag_im_q <= mag_im_d;
      dv_q     <= dv_d;
      side_q   <= {ri_d, rr_d, ord_d, dz_d, num_im[SW-1], num_re[SW-1], op1_q};
    end
  end

  // divider stages
  logic           vd;
  logic [SW-1:0]  quo_re, quo_im;
  logic [SDW-1:0] side_o;

  cia_div_pipe #(
    .OperandWidth(W),
    .SideWidth   (SDW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .num_re_i(mag_re_q),
    .num_im_i(mag_im_q),
    .div_i   (dv_q),
    .side_i  (side_q),
    .valid_o (vd),
    .quo_re_o(quo_re),
    .quo_im_o(quo_im),
    .side_o  (side_o)
  );

  // final select
  cia_pkg::op_e          fop;
  logic                  fneg_re, fneg_im, fdz;
  logic [OrW-1:0]        ford;
  logic signed [SW-1:0]  frr, fri;
  logic signed [FW-1:0]  sq_re, sq_im;
  logic [RW-1:0]         res_re, res_im;

  always_comb begin
    fop     = cia_pkg::op_e'(side_o[OW-1:0]);
    fneg_re = side_o[OW];
    fneg_im = side_o[OW+1];
    fdz     = side_o[OW+2];
    ford    = side_o[OW+3+:OrW];
    frr     = $signed(side_o[OW+3+OrW+:SW]);
    fri     = $signed(side_o[OW+3+OrW+SW+:SW]);
    sq_re   = fneg_re ? -$signed({1'b0, quo_re}) : $signed({1'b0, quo_re});
    sq_im   = fneg_im ? -$signed({1'b0, quo_im}) : $signed({1'b0, quo_im});
    case (fop)
      cia_pkg::OP_DIV: begin
        res_re = fdz ? '0 : RW'(sq_re);
        res_im = fdz ? '0 : RW'(sq_im);
      end
      cia_pkg::OP_CMP, cia_pkg::OP_NOP: begin
        res_re = '0;
        res_im = '0;
      end
      default: begin
        res_re = RW'(frr);
        res_im = RW'(fri);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {{(cia_pkg::OutDataWidth-2*RW-OrW-1){1'b0}},
                     fdz, ford, res_im, res_re};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
